/* hdl/ssp_pkg.sv */
// ssp_pkg: shared types, widths, constants and the arctangent table of the
// swerve steer target planner. No dependencies; compiled first.

package ssp_pkg;

    // field widths
    localparam int STICK_W     = 16;
    localparam int SPEED_W     = 16;
    localparam int ANGLE_W     = 13;
    localparam int MAX_SPEED_W = 14;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_INDEX_W = 2;

    localparam int DRIVE_MOTORS  = 4;
    localparam int STEER_MODULES = 2;

    // square and scale products
    localparam int SUM_W  = 32;
    localparam int MSQ_W  = 2 * MAX_SPEED_W;
    localparam int PROD_W = SUM_W + MSQ_W;

    // square root unit: two radicand bits per step
    localparam int ROOT_IN_W  = PROD_W + 2;
    localparam int ROOT_W     = ROOT_IN_W / 2;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
    localparam int REM_W      = ROOT_W + 3;

    // vectoring cordic
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = 43;
    localparam int CORDIC_SHIFT = 24;
    localparam int ATAN_W       = 19;
    localparam int Z_W          = 22;
    localparam int Z_FRAC       = 8;
    localparam int A0_W         = Z_W - Z_FRAC;
    localparam int QANG_W       = A0_W + 1;

    // 100 * (x*x + y*y) > 2^30 is the same as sum above this value
    localparam logic [SUM_W-1:0] MOVE_THRESHOLD = 32'd10737418;

    // angle constants in ticks, 8192 per turn
    localparam logic signed [QANG_W-1:0] HALF_TURN_Q    = 15'sd4096;
    localparam logic signed [QANG_W-1:0] QUARTER_POS_Q  = 15'sd2048;
    localparam logic signed [QANG_W-1:0] QUARTER_NEG_Q  = -15'sd2048;
    localparam logic [ANGLE_W-1:0]       QUARTER_TURN   = 13'd2048;
    localparam logic [ANGLE_W-1:0]       THREE_QUARTERS = 13'd6144;

    // rounding of the angle accumulator to whole ticks
    localparam logic signed [Z_W-1:0] Z_ROUND = 22'sd128;

    // reset values of the configuration registers
    localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RESET = 14'd1000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_SPEED    = 2'd0,
        CFG_REVERSE_MASK = 2'd1,
        CFG_STEER0_HOME  = 2'd2,
        CFG_STEER1_HOME  = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_M,
        S_SCALE,
        S_LAUNCH,
        S_WAIT,
        S_FOLD,
        S_PLAN
    } plan_state_t;

    // atan(2^-i) in ticks with 8 fraction bits
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 19'd262144;
            5'd1:    val = 19'd154753;
            5'd2:    val = 19'd81767;
            5'd3:    val = 19'd41506;
            5'd4:    val = 19'd20834;
            5'd5:    val = 19'd10427;
            5'd6:    val = 19'd5215;
            5'd7:    val = 19'd2608;
            5'd8:    val = 19'd1304;
            5'd9:    val = 19'd652;
            5'd10:   val = 19'd326;
            5'd11:   val = 19'd163;
            5'd12:   val = 19'd81;
            5'd13:   val = 19'd41;
            5'd14:   val = 19'd20;
            5'd15:   val = 19'd10;
            5'd16:   val = 19'd5;
            5'd17:   val = 19'd3;
            5'd18:   val = 19'd1;
            5'd19:   val = 19'd1;
            default: val = 19'd0;
        endcase
        return val;
    endfunction

    // magnitude of a stick value; -32768 maps to 32768
    function automatic logic [STICK_W-1:0] abs_stick(input logic signed [STICK_W-1:0] v);
        logic [STICK_W-1:0] res;
        res = v[STICK_W-1] ? STICK_W'(-v) : STICK_W'(v);
        return res;
    endfunction

endpackage

/* hdl/ssp_in_if.sv */
// ssp_in_if: command channel of the planner, valid/ready plus one command word.
// Depends on ssp_pkg for field widths.

interface ssp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ssp_pkg::STICK_W-1:0]   stick_x;
    logic signed [ssp_pkg::STICK_W-1:0]   stick_y;
    logic                                 enable_cmd;
    logic [ssp_pkg::STEER_MODULES-1:0]    steer_ready;

    modport source (
        output valid,
        output stick_x,
        output stick_y,
        output enable_cmd,
        output steer_ready,
        input  ready
    );

    modport sink (
        input  valid,
        input  stick_x,
        input  stick_y,
        input  enable_cmd,
        input  steer_ready,
        output ready
    );
endinterface

/* hdl/ssp_out_if.sv */
// ssp_out_if: target channel of the planner, valid/ready plus one target word.
// Depends on ssp_pkg for field widths.

interface ssp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ssp_pkg::SPEED_W-1:0]   drive0_speed;
    logic signed [ssp_pkg::SPEED_W-1:0]   drive1_speed;
    logic signed [ssp_pkg::SPEED_W-1:0]   drive2_speed;
    logic signed [ssp_pkg::SPEED_W-1:0]   drive3_speed;
    logic [ssp_pkg::ANGLE_W-1:0]          steer0_angle;
    logic [ssp_pkg::ANGLE_W-1:0]          steer1_angle;
    logic                                 running;

    modport source (
        output valid,
        output drive0_speed,
        output drive1_speed,
        output drive2_speed,
        output drive3_speed,
        output steer0_angle,
        output steer1_angle,
        output running,
        input  ready
    );

    modport sink (
        input  valid,
        input  drive0_speed,
        input  drive1_speed,
        input  drive2_speed,
        input  drive3_speed,
        input  steer0_angle,
        input  steer1_angle,
        input  running,
        output ready
    );
endinterface

/* hdl/ssp_isqrt.sv */
// ssp_isqrt: iterative integer square root, two radicand bits per cycle.
// Depends on ssp_pkg for widths and step count.

module ssp_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ssp_pkg::ROOT_IN_W-1:0]   radicand,
    output logic [ssp_pkg::ROOT_W-1:0]      root,
    output logic                            done
);

    logic                                busy_reg;
    logic                                busy_next;
    logic                                done_reg;
    logic                                done_next;
    logic [ssp_pkg::ROOT_CNT_W-1:0]      cnt_reg;
    logic [ssp_pkg::ROOT_CNT_W-1:0]      cnt_next;
    logic [ssp_pkg::ROOT_IN_W-1:0]       bits_reg;
    logic [ssp_pkg::ROOT_IN_W-1:0]       bits_next;
    logic [ssp_pkg::REM_W-1:0]           rem_reg;
    logic [ssp_pkg::REM_W-1:0]           rem_next;
    logic [ssp_pkg::ROOT_W-1:0]          root_reg;
    logic [ssp_pkg::ROOT_W-1:0]          root_next;

    logic [ssp_pkg::REM_W-1:0]           rem_shift;
    logic [ssp_pkg::REM_W-1:0]           trial;
    logic                                take;

    // one restoring step: bring down two bits, try root*4+1
    assign rem_shift = {rem_reg[ssp_pkg::REM_W-3:0],
                        bits_reg[ssp_pkg::ROOT_IN_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign take      = (rem_shift >= trial);

    // sequencing of the steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        bits_next = bits_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            bits_next = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            bits_next = {bits_reg[ssp_pkg::ROOT_IN_W-3:0], 2'b00};
            rem_next  = take ? (rem_shift - trial) : rem_shift;
            root_next = {root_reg[ssp_pkg::ROOT_W-2:0], take};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == ssp_pkg::ROOT_CNT_W'(ssp_pkg::ROOT_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

/* hdl/ssp_cordic.sv */
// ssp_cordic: vectoring cordic over the first quadrant, one rotation per cycle,
// angle accumulated in ticks with 8 fraction bits. Depends on ssp_pkg.

module ssp_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ssp_pkg::STICK_W-1:0]       vec_x,
    input  logic [ssp_pkg::STICK_W-1:0]       vec_y,
    output logic signed [ssp_pkg::Z_W-1:0]    angle,
    output logic                              done
);

    logic                                  busy_reg;
    logic                                  busy_next;
    logic                                  done_reg;
    logic                                  done_next;
    logic [ssp_pkg::STEP_W-1:0]            step_reg;
    logic [ssp_pkg::STEP_W-1:0]            step_next;
    logic signed [ssp_pkg::CORDIC_W-1:0]   x_reg;
    logic signed [ssp_pkg::CORDIC_W-1:0]   x_next;
    logic signed [ssp_pkg::CORDIC_W-1:0]   y_reg;
    logic signed [ssp_pkg::CORDIC_W-1:0]   y_next;
    logic signed [ssp_pkg::Z_W-1:0]        z_reg;
    logic signed [ssp_pkg::Z_W-1:0]        z_next;

    logic signed [ssp_pkg::CORDIC_W-1:0]   x_sh;
    logic signed [ssp_pkg::CORDIC_W-1:0]   y_sh;
    logic signed [ssp_pkg::Z_W-1:0]        atan_z;

    // shifted operands and table entry of this step
    assign x_sh   = x_reg >>> step_reg;
    assign y_sh   = y_reg >>> step_reg;
    assign atan_z = ssp_pkg::Z_W'({1'b0, ssp_pkg::atan_entry(step_reg)});

    // rotate toward the x axis
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            x_next    = ssp_pkg::CORDIC_W'({vec_x, ssp_pkg::CORDIC_SHIFT'(0)});
            y_next    = ssp_pkg::CORDIC_W'({vec_y, ssp_pkg::CORDIC_SHIFT'(0)});
            z_next    = '0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[ssp_pkg::CORDIC_W-1])
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_z;
            end
            else
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_z;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == ssp_pkg::STEP_W'(ssp_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign angle = z_reg;
    assign done  = done_reg;

endmodule

/* hdl/swerve_steer_target_planner.sv */
// swerve_steer_target_planner: top level, sequencer, shared multiplier and
// target planning. Depends on ssp_pkg, ssp_in_if, ssp_out_if, ssp_isqrt, ssp_cordic.
//
// Usage
//   cmd: one word per joystick sample (stick_x, stick_y in Q1.15, enable_cmd,
//   steer_ready), taken when valid and ready are both high. ready is high only
//   while the sequencer is idle, so one word is in work at a time.
//   tgt: one word of drive speeds, steer angles and running per command word,
//   held in an output register until valid and ready are both high.
//   cfg: write port, cfg_we with cfg_index selects the register, cfg_data
//   carries the value; write only while no command word is in work.
// Sequence
//   after acceptance a word passes the shared multiplier (squares of x and y,
//   speed square, scale), the launch step, the two-bits-per-cycle square root
//   unit, then wait detect, fold and plan. The cordic runs beside the square
//   root and is never the slower one. The next word is taken in the idle state
//   that follows the plan step.
// Reset
//   rst_n clears the sequencer, the steer offsets (modules at home) and the
//   registers to their defaults (max speed 1000 rpm).
// Stall
//   with the output word still waiting, the plan step holds until the receiver
//   takes it; a command word already waiting at the input is then taken.

module swerve_steer_target_planner (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]      cfg_data,
    ssp_in_if.sink                              cmd,
    ssp_out_if.source                           tgt
);

    // state and configuration
    ssp_pkg::plan_state_t                  state_reg;
    ssp_pkg::plan_state_t                  state_next;
    logic [ssp_pkg::MAX_SPEED_W-1:0]       max_speed_reg;
    logic [ssp_pkg::DRIVE_MOTORS-1:0]      reverse_mask_reg;
    logic [ssp_pkg::ANGLE_W-1:0]           home_reg   [ssp_pkg::STEER_MODULES];
    logic [ssp_pkg::ANGLE_W-1:0]           offset_reg [ssp_pkg::STEER_MODULES];
    logic [ssp_pkg::ANGLE_W-1:0]           offset_next [ssp_pkg::STEER_MODULES];

    // latched command word
    logic signed [ssp_pkg::STICK_W-1:0]    sx_reg;
    logic signed [ssp_pkg::STICK_W-1:0]    sy_reg;
    logic                                  enable_reg;
    logic [ssp_pkg::STEER_MODULES-1:0]     steer_ready_reg;
    logic [ssp_pkg::STICK_W-1:0]           ax_abs;
    logic [ssp_pkg::STICK_W-1:0]           ay_abs;

    // shared multiplier
    logic [ssp_pkg::SUM_W-1:0]             mul_a;
    logic [ssp_pkg::MSQ_W-1:0]             mul_b;
    logic [ssp_pkg::PROD_W-1:0]            prod_reg;
    logic [ssp_pkg::SUM_W-1:0]             sum_reg;

    // unit handshakes
    logic                                  cordic_start;
    logic                                  root_start;
    logic                                  cordic_done;
    logic                                  root_done;
    logic signed [ssp_pkg::Z_W-1:0]        cordic_angle;
    logic [ssp_pkg::ROOT_W-1:0]            root_val;

    // fold stage
    logic signed [ssp_pkg::Z_W-1:0]        z_round;
    logic signed [ssp_pkg::A0_W-1:0]       a0;
    logic signed [ssp_pkg::QANG_W-1:0]     a0_w;
    logic signed [ssp_pkg::QANG_W-1:0]     ang_quad;
    logic signed [ssp_pkg::QANG_W-1:0]     ang_fold;
    logic                                  fold_neg;
    logic [ssp_pkg::SUM_W-1:0]             mag_sum;
    logic [ssp_pkg::ANGLE_W-1:0]           ang_reg;
    logic                                  neg_reg;
    logic [ssp_pkg::SPEED_W-1:0]           mag_reg;

    // plan stage
    logic                                  moving;
    logic [ssp_pkg::ANGLE_W-1:0]           diff;
    logic                                  flip;
    logic                                  neg_final;
    logic [ssp_pkg::ANGLE_W-1:0]           new_offset;
    logic                                  commit;
    logic                                  out_free;
    logic signed [ssp_pkg::SPEED_W-1:0]    speed_next [ssp_pkg::DRIVE_MOTORS];

    // output register
    logic                                  out_valid_reg;
    logic signed [ssp_pkg::SPEED_W-1:0]    speed_reg [ssp_pkg::DRIVE_MOTORS];
    logic [ssp_pkg::ANGLE_W-1:0]           angle_reg [ssp_pkg::STEER_MODULES];
    logic                                  running_reg;

    assign ax_abs = ssp_pkg::abs_stick(sx_reg);
    assign ay_abs = ssp_pkg::abs_stick(sy_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssp_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ssp_pkg::S_SQ_X;
                end
            end
            ssp_pkg::S_SQ_X:   state_next = ssp_pkg::S_SQ_Y;
            ssp_pkg::S_SQ_Y:   state_next = ssp_pkg::S_SQ_M;
            ssp_pkg::S_SQ_M:   state_next = ssp_pkg::S_SCALE;
            ssp_pkg::S_SCALE:  state_next = ssp_pkg::S_LAUNCH;
            ssp_pkg::S_LAUNCH: state_next = ssp_pkg::S_WAIT;
            ssp_pkg::S_WAIT:
            begin
                if (root_done && cordic_done)
                begin
                    state_next = ssp_pkg::S_FOLD;
                end
            end
            ssp_pkg::S_FOLD:   state_next = ssp_pkg::S_PLAN;
            ssp_pkg::S_PLAN:
            begin
                if (out_free)
                begin
                    state_next = ssp_pkg::S_IDLE;
                end
            end
            default:           state_next = ssp_pkg::S_IDLE;
        endcase
    end

    assign out_free = !out_valid_reg || tgt.ready;

    // sequencer outputs and multiplier operand select
    always_comb
    begin
        cmd.ready    = 1'b0;
        cordic_start = 1'b0;
        root_start   = 1'b0;
        commit       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        case (state_reg)
            ssp_pkg::S_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            ssp_pkg::S_SQ_X:
            begin
                cordic_start = 1'b1;
                mul_a        = ssp_pkg::SUM_W'(ax_abs);
                mul_b        = ssp_pkg::MSQ_W'(ax_abs);
            end
            ssp_pkg::S_SQ_Y:
            begin
                mul_a = ssp_pkg::SUM_W'(ay_abs);
                mul_b = ssp_pkg::MSQ_W'(ay_abs);
            end
            ssp_pkg::S_SQ_M:
            begin
                mul_a = ssp_pkg::SUM_W'(max_speed_reg);
                mul_b = ssp_pkg::MSQ_W'(max_speed_reg);
            end
            ssp_pkg::S_SCALE:
            begin
                mul_a = sum_reg;
                mul_b = prod_reg[ssp_pkg::MSQ_W-1:0];
            end
            ssp_pkg::S_LAUNCH:
            begin
                root_start = 1'b1;
            end
            ssp_pkg::S_PLAN:
            begin
                commit = out_free;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    // sequencer and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ssp_pkg::S_IDLE;
            max_speed_reg    <= ssp_pkg::MAX_SPEED_RESET;
            reverse_mask_reg <= '0;
            for (int m = 0; m < ssp_pkg::STEER_MODULES; m++)
            begin
                home_reg[m]   <= '0;
                offset_reg[m] <= '0;
            end
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (ssp_pkg::cfg_index_t'(cfg_index))
                    ssp_pkg::CFG_MAX_SPEED:
                        max_speed_reg <= cfg_data[ssp_pkg::MAX_SPEED_W-1:0];
                    ssp_pkg::CFG_REVERSE_MASK:
                        reverse_mask_reg <= cfg_data[ssp_pkg::DRIVE_MOTORS-1:0];
                    ssp_pkg::CFG_STEER0_HOME:
                        home_reg[0] <= cfg_data[ssp_pkg::ANGLE_W-1:0];
                    ssp_pkg::CFG_STEER1_HOME:
                        home_reg[1] <= cfg_data[ssp_pkg::ANGLE_W-1:0];
                    default:
                        max_speed_reg <= max_speed_reg;
                endcase
            end
            if (commit)
            begin
                for (int m = 0; m < ssp_pkg::STEER_MODULES; m++)
                begin
                    offset_reg[m] <= offset_next[m];
                end
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tgt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command latch and multiplier products
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            sx_reg          <= cmd.stick_x;
            sy_reg          <= cmd.stick_y;
            enable_reg      <= cmd.enable_cmd;
            steer_ready_reg <= cmd.steer_ready;
        end
        prod_reg <= ssp_pkg::PROD_W'(mul_a) * ssp_pkg::PROD_W'(mul_b);
        case (state_reg)
            ssp_pkg::S_SQ_Y: sum_reg <= prod_reg[ssp_pkg::SUM_W-1:0];
            ssp_pkg::S_SQ_M: sum_reg <= sum_reg + prod_reg[ssp_pkg::SUM_W-1:0];
            default:         sum_reg <= sum_reg;
        endcase
    end

    // heading of (-stick_y, stick_x) in the first quadrant
    ssp_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .vec_x  (ay_abs),
        .vec_y  (ax_abs),
        .angle  (cordic_angle),
        .done   (cordic_done)
    );

    // magnitude times max speed, doubled: sqrt(4 * sum * m * m)
    ssp_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand ({prod_reg, 2'b00}),
        .root     (root_val),
        .done     (root_done)
    );

    // round heading, place it in its quadrant, fold into half a turn
    always_comb
    begin
        z_round  = cordic_angle + ssp_pkg::Z_ROUND;
        a0       = z_round[ssp_pkg::Z_W-1:ssp_pkg::Z_FRAC];
        a0_w     = ssp_pkg::QANG_W'(a0);
        if (sy_reg[ssp_pkg::STICK_W-1] || (sy_reg == '0))
        begin
            ang_quad = sx_reg[ssp_pkg::STICK_W-1] ? -a0_w : a0_w;
        end
        else
        begin
            ang_quad = sx_reg[ssp_pkg::STICK_W-1] ? (a0_w - ssp_pkg::HALF_TURN_Q)
                                                  : (ssp_pkg::HALF_TURN_Q - a0_w);
        end
        fold_neg = 1'b0;
        ang_fold = ang_quad;
        if (ang_quad > ssp_pkg::QUARTER_POS_Q)
        begin
            ang_fold = ang_quad - ssp_pkg::HALF_TURN_Q;
            fold_neg = 1'b1;
        end
        else if (ang_quad < ssp_pkg::QUARTER_NEG_Q)
        begin
            ang_fold = ang_quad + ssp_pkg::HALF_TURN_Q;
            fold_neg = 1'b1;
        end
        mag_sum = ssp_pkg::SUM_W'(root_val) + 32'd32768;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ssp_pkg::S_FOLD)
        begin
            ang_reg <= ang_fold[ssp_pkg::ANGLE_W-1:0];
            neg_reg <= fold_neg;
            mag_reg <= mag_sum[ssp_pkg::SUM_W-1 -: ssp_pkg::SPEED_W];
        end
    end

    // shortest turn against steer module zero, offsets and speeds
    always_comb
    begin
        moving     = (sum_reg > ssp_pkg::MOVE_THRESHOLD);
        diff       = ang_reg - offset_reg[0];
        flip       = steer_ready_reg[0] && (diff > ssp_pkg::QUARTER_TURN)
                     && (diff < ssp_pkg::THREE_QUARTERS);
        neg_final  = neg_reg ^ flip;
        new_offset = {ang_reg[ssp_pkg::ANGLE_W-1] ^ flip, ang_reg[ssp_pkg::ANGLE_W-2:0]};
        for (int m = 0; m < ssp_pkg::STEER_MODULES; m++)
        begin
            if (moving && steer_ready_reg[0] && steer_ready_reg[m])
            begin
                offset_next[m] = new_offset;
            end
            else
            begin
                offset_next[m] = offset_reg[m];
            end
        end
        for (int d = 0; d < ssp_pkg::DRIVE_MOTORS; d++)
        begin
            if (!moving)
            begin
                speed_next[d] = '0;
            end
            else if (neg_final ^ reverse_mask_reg[d])
            begin
                speed_next[d] = ssp_pkg::SPEED_W'(-$signed(mag_reg));
            end
            else
            begin
                speed_next[d] = $signed(mag_reg);
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            for (int d = 0; d < ssp_pkg::DRIVE_MOTORS; d++)
            begin
                speed_reg[d] <= speed_next[d];
            end
            for (int m = 0; m < ssp_pkg::STEER_MODULES; m++)
            begin
                angle_reg[m] <= home_reg[m] + offset_next[m];
            end
            running_reg <= enable_reg;
        end
    end

    assign tgt.valid        = out_valid_reg;
    assign tgt.drive0_speed = speed_reg[0];
    assign tgt.drive1_speed = speed_reg[1];
    assign tgt.drive2_speed = speed_reg[2];
    assign tgt.drive3_speed = speed_reg[3];
    assign tgt.steer0_angle = angle_reg[0];
    assign tgt.steer1_angle = angle_reg[1];
    assign tgt.running      = running_reg;

endmodule
